[rtl/lobm_pkg.sv]
// Shared types, codes and defaults for the limit order book matcher.
`timescale 1ns / 1ps

package lobm_pkg;

    localparam int LOBM_ORDER_SLOTS  = 1024;
    localparam int LOBM_PRICE_LEVELS = 4096;
    localparam int LOBM_QTY_BITS     = 32;

    // request types
    localparam logic [1:0] REQ_ADD    = 2'd0;
    localparam logic [1:0] REQ_MARKET = 2'd1;
    localparam logic [1:0] REQ_CANCEL = 2'd2;
    localparam logic [1:0] REQ_NONE   = 2'd3;

    // result status
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_DUP     = 2'd1;
    localparam logic [1:0] ST_UNKNOWN = 2'd2;
    localparam logic [1:0] ST_FULL    = 2'd3;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [9:0]  ord_id;
        logic        side;
        logic [11:0] price;
        logic [31:0] quantity;
    } req_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] filled_qty;
        logic [31:0] dropped_qty;
        logic        bid_valid;
        logic [11:0] best_bid;
        logic        ask_valid;
        logic [11:0] best_ask;
        logic [10:0] order_count;
    } rsp_t;

endpackage

[rtl/limit_order_book_matcher_unit.sv]
// Limit order book matcher: order store, price levels, occupancy bitmap and sequencer.
// A market order fills resting orders in turn, each in full until the last, which may fill in part.
// One request at a time: a new transfer is taken once the result shows; a result still
// waiting holds the sequencer in S_OUT. Reset: rst_n asynchronous, active low, then a
// clearing pass over all ORDER_SLOTS order slots with req_stall high.
`timescale 1ns / 1ps

module limit_order_book_matcher_unit #(
    parameter int ORDER_SLOTS  = lobm_pkg::LOBM_ORDER_SLOTS,
    parameter int PRICE_LEVELS = lobm_pkg::LOBM_PRICE_LEVELS,
    parameter int QTY_BITS     = lobm_pkg::LOBM_QTY_BITS
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_stall,
    input  lobm_pkg::req_t req_data,
    output logic           rsp_valid,
    input  logic           rsp_stall,
    output lobm_pkg::rsp_t rsp_data
);
    import lobm_pkg::*;

    // slot index and resting count widths
    localparam int SLOT_W  = $clog2(ORDER_SLOTS);
    localparam int CNT_W   = $clog2(ORDER_SLOTS + 1);
    // price split into bitmap word index and bit within word (both at least one bit)
    localparam int PRICE_W = ($clog2(PRICE_LEVELS) < 2) ? 2 : $clog2(PRICE_LEVELS);
    localparam int BIT_W   = (PRICE_W > 6) ? 6 : PRICE_W - 1;
    localparam int WIDX_W  = PRICE_W - BIT_W;
    localparam int NW      = 2 ** WIDX_W;
    localparam int WB      = 2 ** BIT_W;
    localparam int LVL_W   = PRICE_W + 1;

    // sequencer states
    localparam logic [3:0] S_CLR     = 4'd0;
    localparam logic [3:0] S_IDLE    = 4'd1;
    localparam logic [3:0] S_RD_ID   = 4'd2;
    localparam logic [3:0] S_ADD_LV  = 4'd3;
    localparam logic [3:0] S_ADD_T   = 4'd4;
    localparam logic [3:0] S_UL_LV   = 4'd5;
    localparam logic [3:0] S_UL_B    = 4'd6;
    localparam logic [3:0] S_UL_F    = 4'd7;
    localparam logic [3:0] S_MK_FIND = 4'd8;
    localparam logic [3:0] S_MK_WORD = 4'd9;
    localparam logic [3:0] S_MK_LV   = 4'd10;
    localparam logic [3:0] S_MK_SLOT = 4'd11;
    localparam logic [3:0] S_BEST0   = 4'd12;
    localparam logic [3:0] S_BEST1   = 4'd13;
    localparam logic [3:0] S_BEST2   = 4'd14;
    localparam logic [3:0] S_OUT     = 4'd15;

    typedef struct packed {
        logic                valid;
        logic                side;
        logic [PRICE_W-1:0]  price;
        logic [QTY_BITS-1:0] remaining;
        logic [SLOT_W-1:0]   fwd;
        logic [SLOT_W-1:0]   back;
    } slot_t;

    typedef struct packed {
        logic [SLOT_W-1:0] head;
        logic [SLOT_W-1:0] tail;
    } level_t;

    // Summary bitmap: highest set index when hi, else lowest.
    function automatic logic [WIDX_W-1:0] sum_find(input logic [NW-1:0] v, input logic hi);
        logic [WIDX_W-1:0] r;
        logic              f;
        r = '0;
        f = 1'b0;
        for (int i = 0; i < NW; i++) begin
            if (v[i]) begin
                if (hi || !f)
                    r = WIDX_W'(i);
                f = 1'b1;
            end
        end
        return r;
    endfunction

    function automatic logic [BIT_W-1:0] word_find(input logic [WB-1:0] v, input logic hi);
        logic [BIT_W-1:0] r;
        logic             f;
        r = '0;
        f = 1'b0;
        for (int i = 0; i < WB; i++) begin
            if (v[i]) begin
                if (hi || !f)
                    r = BIT_W'(i);
                f = 1'b1;
            end
        end
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Memories: order slots, level queues (head/tail), occupancy words.
    // A level entry is only trusted when its occupancy bit is set, and an
    // occupancy word only when its summary bit (flip-flops) is set, so
    // neither needs clearing after reset.
    // ------------------------------------------------------------------
    slot_t             slot_mem [ORDER_SLOTS];
    level_t            lvl_mem  [2 ** LVL_W];
    logic [WB-1:0]     bm_mem   [2 * NW];

    logic              slot_we;
    logic [SLOT_W-1:0] slot_waddr, slot_raddr;
    slot_t             slot_wdata, slot_rd;
    logic              lvl_we;
    logic [LVL_W-1:0]  lvl_waddr, lvl_raddr;
    level_t            lvl_wdata, lvl_rd;
    logic              bm_we;
    logic [WIDX_W:0]   bm_waddr, bm_raddr;
    logic [WB-1:0]     bm_wdata, bm_rd;

    always_ff @(posedge clk)
    begin
        if (slot_we)
            slot_mem[slot_waddr] <= slot_wdata;
        slot_rd <= slot_mem[slot_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (lvl_we)
            lvl_mem[lvl_waddr] <= lvl_wdata;
        lvl_rd <= lvl_mem[lvl_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (bm_we)
            bm_mem[bm_waddr] <= bm_wdata;
        bm_rd <= bm_mem[bm_raddr];
    end

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    logic [3:0]          state_reg, state_next;
    logic [SLOT_W-1:0]   clr_reg, clr_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic [1:0][NW-1:0]  sum_reg, sum_next;
    logic                rsp_valid_reg, rsp_valid_next;

    logic [1:0]          req_type_reg, req_type_next;
    logic [SLOT_W-1:0]   sid_reg, sid_next;
    logic                in_store_reg, in_store_next;
    logic                side_reg, side_next;
    logic [PRICE_W-1:0]  price_reg, price_next;
    logic [QTY_BITS-1:0] rem_reg, rem_next;
    logic [QTY_BITS-1:0] filled_reg, filled_next;
    logic [QTY_BITS-1:0] dropped_reg, dropped_next;
    logic [1:0]          status_reg, status_next;
    logic [SLOT_W-1:0]   vic_id_reg, vic_id_next;
    slot_t               vic_reg, vic_next;
    logic [SLOT_W-1:0]   t_reg, t_next;
    logic [WIDX_W-1:0]   widx_reg, widx_next;
    logic                bid_valid_reg, bid_valid_next;
    logic [PRICE_W-1:0]  bid_reg, bid_next;
    logic                ask_valid_reg, ask_valid_next;
    logic [PRICE_W-1:0]  ask_reg, ask_next;
    rsp_t                rsp_reg, rsp_next;

    // scratch for the sequencer
    logic                opp;
    logic                occ;
    logic                is_head, is_tail;
    logic [WB-1:0]       word_new;
    logic [QTY_BITS-1:0] take, left;
    logic [WIDX_W-1:0]   w_sel;
    logic [PRICE_W-1:0]  p_sel;
    logic [16:0]         price_ext;
    slot_t               slot_mod;
    logic [CNT_W-1:0]    slot_cap;

    assign slot_cap = CNT_W'(ORDER_SLOTS);

    always_comb
    begin
        state_next     = state_reg;
        clr_next       = clr_reg;
        cnt_next       = cnt_reg;
        sum_next       = sum_reg;
        rsp_valid_next = rsp_valid_reg & rsp_stall;
        req_type_next  = req_type_reg;
        sid_next       = sid_reg;
        in_store_next  = in_store_reg;
        side_next      = side_reg;
        price_next     = price_reg;
        rem_next       = rem_reg;
        filled_next    = filled_reg;
        dropped_next   = dropped_reg;
        status_next    = status_reg;
        vic_id_next    = vic_id_reg;
        vic_next       = vic_reg;
        t_next         = t_reg;
        widx_next      = widx_reg;
        bid_valid_next = bid_valid_reg;
        bid_next       = bid_reg;
        ask_valid_next = ask_valid_reg;
        ask_next       = ask_reg;
        rsp_next       = rsp_reg;

        slot_we    = 1'b0;
        slot_waddr = sid_reg;
        slot_wdata = slot_rd;
        slot_raddr = sid_reg;
        lvl_we     = 1'b0;
        lvl_waddr  = {side_reg, price_reg};
        lvl_wdata  = lvl_rd;
        lvl_raddr  = {side_reg, price_reg};
        bm_we      = 1'b0;
        bm_waddr   = {side_reg, price_reg[PRICE_W-1:BIT_W]};
        bm_wdata   = bm_rd;
        bm_raddr   = {side_reg, price_reg[PRICE_W-1:BIT_W]};

        opp       = ~side_reg;
        occ       = 1'b0;
        is_head   = 1'b0;
        is_tail   = 1'b0;
        word_new  = '0;
        take      = '0;
        left      = '0;
        w_sel     = '0;
        p_sel     = '0;
        price_ext = 17'(req_data.price);
        slot_mod  = slot_rd;

        unique case (state_reg)
            S_CLR:
            begin
                slot_we    = 1'b1;
                slot_waddr = clr_reg;
                slot_wdata = '0;
                if (clr_reg == SLOT_W'(ORDER_SLOTS - 1))
                    state_next = S_IDLE;
                else
                    clr_next = clr_reg + 1'b1;
            end

            S_IDLE:
            begin
                slot_raddr = SLOT_W'(req_data.ord_id);
                if (req_valid)
                begin
                    req_type_next = req_data.req_type;
                    sid_next      = SLOT_W'(req_data.ord_id);
                    in_store_next = 32'(req_data.ord_id) < 32'(ORDER_SLOTS);
                    side_next     = req_data.side;
                    price_next    = (price_ext >= 17'(PRICE_LEVELS))
                                    ? PRICE_W'(PRICE_LEVELS - 1)
                                    : PRICE_W'(req_data.price);
                    rem_next      = QTY_BITS'(req_data.quantity);
                    filled_next   = '0;
                    dropped_next  = '0;
                    status_next   = ST_OK;
                    state_next    = S_RD_ID;
                end
            end

            S_RD_ID:
            begin
                case (req_type_reg)
                    REQ_ADD:
                    begin
                        // level and bitmap reads for the add go out on the defaults
                        if (in_store_reg && slot_rd.valid)
                        begin
                            status_next = ST_DUP;
                            state_next  = S_BEST0;
                        end
                        else if (!in_store_reg || cnt_reg >= slot_cap)
                        begin
                            status_next = ST_FULL;
                            state_next  = S_BEST0;
                        end
                        else if (rem_reg == '0)
                            state_next = S_BEST0;
                        else
                            state_next = S_ADD_LV;
                    end
                    REQ_MARKET:
                    begin
                        if (in_store_reg && slot_rd.valid)
                        begin
                            status_next = ST_DUP;
                            state_next  = S_BEST0;
                        end
                        else
                            state_next = S_MK_FIND;
                    end
                    REQ_CANCEL:
                    begin
                        if (in_store_reg && slot_rd.valid)
                        begin
                            vic_id_next = sid_reg;
                            vic_next    = slot_rd;
                            lvl_raddr   = {slot_rd.side, slot_rd.price};
                            bm_raddr    = {slot_rd.side, slot_rd.price[PRICE_W-1:BIT_W]};
                            state_next  = S_UL_LV;
                        end
                        else
                        begin
                            status_next = ST_UNKNOWN;
                            state_next  = S_BEST0;
                        end
                    end
                    default:
                        state_next = S_BEST0;
                endcase
            end

            S_ADD_LV:
            begin
                occ = sum_reg[side_reg][price_reg[PRICE_W-1:BIT_W]]
                      && bm_rd[price_reg[BIT_W-1:0]];
                slot_we    = 1'b1;
                slot_waddr = sid_reg;
                slot_wdata = '{valid: 1'b1, side: side_reg, price: price_reg,
                               remaining: rem_reg, fwd: '0,
                               back: occ ? lvl_rd.tail : '0};
                lvl_we     = 1'b1;
                lvl_wdata  = '{head: occ ? lvl_rd.head : sid_reg, tail: sid_reg};
                cnt_next   = cnt_reg + 1'b1;
                if (occ)
                begin
                    // old tail needs its forward link pointed at the newcomer
                    slot_raddr = lvl_rd.tail;
                    t_next     = lvl_rd.tail;
                    state_next = S_ADD_T;
                end
                else
                begin
                    word_new = sum_reg[side_reg][price_reg[PRICE_W-1:BIT_W]] ? bm_rd : '0;
                    bm_we    = 1'b1;
                    bm_wdata = word_new | (WB'(1) << price_reg[BIT_W-1:0]);
                    sum_next[side_reg][price_reg[PRICE_W-1:BIT_W]] = 1'b1;
                    state_next = S_BEST0;
                end
            end

            S_ADD_T:
            begin
                slot_mod     = slot_rd;
                slot_mod.fwd = sid_reg;
                slot_we      = 1'b1;
                slot_waddr   = t_reg;
                slot_wdata   = slot_mod;
                state_next   = S_BEST0;
            end

            S_UL_LV:
            begin
                is_head        = lvl_rd.head == vic_id_reg;
                is_tail        = lvl_rd.tail == vic_id_reg;
                slot_mod       = vic_reg;
                slot_mod.valid = 1'b0;
                slot_we        = 1'b1;
                slot_waddr     = vic_id_reg;
                slot_wdata     = slot_mod;
                lvl_waddr      = {vic_reg.side, vic_reg.price};
                bm_waddr       = {vic_reg.side, vic_reg.price[PRICE_W-1:BIT_W]};
                if (cnt_reg != '0)
                    cnt_next = cnt_reg - 1'b1;
                state_next = (req_type_reg == REQ_MARKET) ? S_MK_FIND : S_BEST0;
                if (is_head && is_tail)
                begin
                    // last order of the level: drop the occupancy bit
                    word_new = bm_rd & ~(WB'(1) << vic_reg.price[BIT_W-1:0]);
                    bm_we    = 1'b1;
                    bm_wdata = word_new;
                    if (word_new == '0)
                        sum_next[vic_reg.side][vic_reg.price[PRICE_W-1:BIT_W]] = 1'b0;
                end
                else if (is_head)
                begin
                    lvl_we    = 1'b1;
                    lvl_wdata = '{head: vic_reg.fwd, tail: lvl_rd.tail};
                end
                else if (is_tail)
                begin
                    lvl_we    = 1'b1;
                    lvl_wdata = '{head: lvl_rd.head, tail: vic_reg.back};
                end
                else
                begin
                    slot_raddr = vic_reg.back;
                    state_next = S_UL_B;
                end
            end

            S_UL_B:
            begin
                slot_mod     = slot_rd;
                slot_mod.fwd = vic_reg.fwd;
                slot_we      = 1'b1;
                slot_waddr   = vic_reg.back;
                slot_wdata   = slot_mod;
                slot_raddr   = vic_reg.fwd;
                state_next   = S_UL_F;
            end

            S_UL_F:
            begin
                slot_mod      = slot_rd;
                slot_mod.back = vic_reg.back;
                slot_we       = 1'b1;
                slot_waddr    = vic_reg.fwd;
                slot_wdata    = slot_mod;
                state_next    = (req_type_reg == REQ_MARKET) ? S_MK_FIND : S_BEST0;
            end

            S_MK_FIND:
            begin
                if (rem_reg == '0)
                    state_next = S_BEST0;
                else if (sum_reg[opp] == '0)
                begin
                    dropped_next = rem_reg;
                    state_next   = S_BEST0;
                end
                else
                begin
                    // buys rest best at the top, sells at the bottom
                    w_sel      = sum_find(sum_reg[opp], ~opp);
                    widx_next  = w_sel;
                    bm_raddr   = {opp, w_sel};
                    state_next = S_MK_WORD;
                end
            end

            S_MK_WORD:
            begin
                p_sel      = {widx_reg, word_find(bm_rd, ~opp)};
                lvl_raddr  = {opp, p_sel};
                state_next = S_MK_LV;
            end

            S_MK_LV:
            begin
                slot_raddr  = lvl_rd.head;
                vic_id_next = lvl_rd.head;
                state_next  = S_MK_SLOT;
            end

            S_MK_SLOT:
            begin
                take        = (rem_reg < slot_rd.remaining) ? rem_reg : slot_rd.remaining;
                left        = slot_rd.remaining - take;
                rem_next    = rem_reg - take;
                filled_next = filled_reg + take;
                if (left == '0)
                begin
                    vic_next   = slot_rd;
                    lvl_raddr  = {slot_rd.side, slot_rd.price};
                    bm_raddr   = {slot_rd.side, slot_rd.price[PRICE_W-1:BIT_W]};
                    state_next = S_UL_LV;
                end
                else
                begin
                    // partial fill: market order is exhausted
                    slot_mod           = slot_rd;
                    slot_mod.remaining = left;
                    slot_we            = 1'b1;
                    slot_waddr         = vic_id_reg;
                    slot_wdata         = slot_mod;
                    state_next         = S_BEST0;
                end
            end

            S_BEST0:
            begin
                w_sel      = sum_find(sum_reg[0], 1'b1);
                widx_next  = w_sel;
                bm_raddr   = {1'b0, w_sel};
                state_next = S_BEST1;
            end

            S_BEST1:
            begin
                bid_valid_next = |sum_reg[0];
                bid_next       = (|sum_reg[0]) ? {widx_reg, word_find(bm_rd, 1'b1)} : '0;
                w_sel          = sum_find(sum_reg[1], 1'b0);
                widx_next      = w_sel;
                bm_raddr       = {1'b1, w_sel};
                state_next     = S_BEST2;
            end

            S_BEST2:
            begin
                ask_valid_next = |sum_reg[1];
                ask_next       = (|sum_reg[1]) ? {widx_reg, word_find(bm_rd, 1'b0)} : '0;
                state_next     = S_OUT;
            end

            S_OUT:
            begin
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    rsp_next = '{status:      status_reg,
                                 filled_qty:  32'(filled_reg),
                                 dropped_qty: 32'(dropped_reg),
                                 bid_valid:   bid_valid_reg,
                                 best_bid:    12'(bid_reg),
                                 ask_valid:   ask_valid_reg,
                                 best_ask:    12'(ask_reg),
                                 order_count: 11'(cnt_reg)};
                    rsp_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end

            default:
                state_next = S_IDLE;
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLR;
            clr_reg       <= '0;
            cnt_reg       <= '0;
            sum_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            cnt_reg       <= cnt_next;
            sum_reg       <= sum_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // payload and working registers
    always_ff @(posedge clk)
    begin
        req_type_reg  <= req_type_next;
        sid_reg       <= sid_next;
        in_store_reg  <= in_store_next;
        side_reg      <= side_next;
        price_reg     <= price_next;
        rem_reg       <= rem_next;
        filled_reg    <= filled_next;
        dropped_reg   <= dropped_next;
        status_reg    <= status_next;
        vic_id_reg    <= vic_id_next;
        vic_reg       <= vic_next;
        t_reg         <= t_next;
        widx_reg      <= widx_next;
        bid_valid_reg <= bid_valid_next;
        bid_reg       <= bid_next;
        ask_valid_reg <= ask_valid_next;
        ask_reg       <= ask_next;
        rsp_reg       <= rsp_next;
    end

    // new request only taken when the sequencer is free; the result register
    // keeps the previous transfer waiting meanwhile
    assign req_stall = (state_reg != S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_reg;

endmodule

[rtl/lobm_checker.sv]
// Port-level checks for the limit order book matcher, bound to the top level.
`timescale 1ns / 1ps

module lobm_checker (
    input logic           clk,
    input logic           rst_n,
    input logic           req_valid,
    input logic           req_stall,
    input logic           rsp_valid,
    input logic           rsp_stall,
    input lobm_pkg::rsp_t rsp_data
);
    import lobm_pkg::*;

    // stalled result holds
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
        else $error("result changed while stalled");

    // empty side reports price zero
    a_empty_side: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (rsp_data.bid_valid || rsp_data.best_bid == '0)
                   && (rsp_data.ask_valid || rsp_data.best_ask == '0))
        else $error("best price set on an empty side");

    // refused requests trade nothing
    a_refused_no_fill: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_data.status != ST_OK
            |-> rsp_data.filled_qty == '0 && rsp_data.dropped_qty == '0)
        else $error("refused request reports quantity");

    // one request at a time: busy right after a transfer in
    a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall |=> req_stall)
        else $error("second request taken back to back");

    // clearing pass holds off requests after reset
    a_clear_after_reset: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rst_n) |-> req_stall)
        else $error("request port open during clearing pass");

endmodule

bind limit_order_book_matcher_unit lobm_checker u_lobm_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp_data  (rsp_data)
);
